FILE: src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants and codes for the line segment clipper.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int unsigned COORD_BITS_DEF      = 16;
  localparam int unsigned PARAM_FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_BITS        = 8;
  localparam int unsigned FIFO_DEPTH          = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEFT   = 8'd0,
    REG_RIGHT  = 8'd1,
    REG_BOTTOM = 8'd2,
    REG_TOP    = 8'd3
  } cfg_reg_e;

endpackage

FILE: src/lsc_if.sv
// ----------------------------------------------------------------------------
// lsc channel interfaces
// Segment input, clip result and register write channels.
// ----------------------------------------------------------------------------
interface lsc_seg_if #(
  parameter int unsigned CoordBits = lsc_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] start_x;
  logic signed [CoordBits-1:0] start_y;
  logic signed [CoordBits-1:0] end_x;
  logic signed [CoordBits-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_res_if #(
  parameter int unsigned CoordBits = lsc_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        visible;
  logic signed [CoordBits-1:0] clipped_start_x;
  logic signed [CoordBits-1:0] clipped_start_y;
  logic signed [CoordBits-1:0] clipped_end_x;
  logic signed [CoordBits-1:0] clipped_end_y;

  modport source (output valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, input ready);
  modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, output ready);
endinterface

interface lsc_cfg_if #(
  parameter int unsigned CoordBits = lsc_pkg::COORD_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [lsc_pkg::CFG_IDX_BITS-1:0]    index;
  logic [CoordBits-1:0]                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/line_segment_clipper.sv
// ----------------------------------------------------------------------------
// line_segment_clipper
// Clips 2D segments against a programmable axis-aligned window.
//
//   channel  modport  carries
//   seg_i    sink     start_x, start_y, end_x, end_y
//   res_o    source   visible, clipped start and end point
//   cfg_i    sink     window register index and value
//
// One segment per cycle sustained unless the result stalls; each segment
// passes the queue and the four pipelined ratio dividers (one quotient
// bit per stage). Reset clears the window to the full coordinate range.
// A stalled result freezes the back pipeline; the four-entry queue keeps
// taking segments until it fills.
// ----------------------------------------------------------------------------
module line_segment_clipper #(
  parameter int unsigned COORD_BITS      = lsc_pkg::COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = lsc_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lsc_seg_if.sink  seg_i,
  lsc_res_if.source res_o,
  lsc_cfg_if.sink  cfg_i
);
  localparam int unsigned ENTRY_W = 12 * COORD_BITS + 18;

  logic               q_full, q_push, q_empty, q_pop;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  lsc_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .seg      (seg_i),
    .cfg      (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  lsc_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  lsc_back #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .res       (res_o)
  );

endmodule

FILE: src/lsc_front.sv
// ----------------------------------------------------------------------------
// lsc_front
// Window registers and per-edge classification of incoming segments.
// ----------------------------------------------------------------------------
module lsc_front #(
  parameter int unsigned COORD_BITS = lsc_pkg::COORD_BITS_DEF,
  parameter int unsigned ENTRY_W    = 12 * COORD_BITS + 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lsc_seg_if.sink            seg,
  lsc_cfg_if.sink            cfg,
  input  logic               q_full_i,
  output logic               q_push_o,
  output logic [ENTRY_W-1:0] q_data_o
);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned EW = 2 * C + 4;

  logic signed [C-1:0] left_q, right_q, bottom_q, top_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= {1'b1, {(C-1){1'b0}}};
      right_q  <= {1'b0, {(C-1){1'b1}}};
      bottom_q <= {1'b1, {(C-1){1'b0}}};
      top_q    <= {1'b0, {(C-1){1'b1}}};
    end else if (cfg.valid) begin
      case (cfg.index)
        lsc_pkg::REG_LEFT:   left_q   <= cfg.data;
        lsc_pkg::REG_RIGHT:  right_q  <= cfg.data;
        lsc_pkg::REG_BOTTOM: bottom_q <= cfg.data;
        lsc_pkg::REG_TOP:    top_q    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign seg.ready = !q_full_i;
  assign q_push_o  = seg.valid && !q_full_i;

  always_comb begin
    logic signed [C:0] x0, y0, dx, dy;
    logic signed [C:0] p [4];
    logic signed [C:0] q [4];
    logic signed [C:0] ap, aq;
    logic [C-1:0]      np, nq;
    logic              sat;
    x0 = {seg.start_x[C-1], seg.start_x};
    y0 = {seg.start_y[C-1], seg.start_y};
    dx = {seg.end_x[C-1], seg.end_x} - x0;
    dy = {seg.end_y[C-1], seg.end_y} - y0;
    p[0] = -dx;
    q[0] = x0 - {left_q[C-1], left_q};
    p[1] = dx;
    q[1] = {right_q[C-1], right_q} - x0;
    p[2] = -dy;
    q[2] = y0 - {bottom_q[C-1], bottom_q};
    p[3] = dy;
    q[3] = {top_q[C-1], top_q} - y0;
    q_data_o = '0;
    for (int e = 0; e < 4; e++) begin
      ap  = p[e][C] ? -p[e] : p[e];
      aq  = q[e][C] ? -q[e] : q[e];
      np  = ap[C-1:0];
      nq  = aq[C-1:0];
      sat = {1'b0, nq} >= {np, 1'b0};
      q_data_o[e*EW +: EW] = {(p[e] == '0), q[e][C], p[e][C], sat, np, nq};
    end
    q_data_o[4*EW +: 4*C+2] = {x0[C-1:0], y0[C-1:0], dx, dy};
  end

endmodule

FILE: src/lsc_fifo.sv
// ----------------------------------------------------------------------------
// lsc_fifo
// Short queue between classification and the clipping pipeline.
// ----------------------------------------------------------------------------
module lsc_fifo #(
  parameter int unsigned WIDTH = 210
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned D  = lsc_pkg::FIFO_DEPTH;
  localparam int unsigned PW = $clog2(D);
  localparam int unsigned CW = $clog2(D + 1);

  logic [WIDTH-1:0] mem_q [D];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = cnt_q == CW'(D);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/lsc_back.sv
// ----------------------------------------------------------------------------
// lsc_back
// Ratio division pipeline, parameter narrowing and endpoint interpolation.
// ----------------------------------------------------------------------------
module lsc_back #(
  parameter int unsigned COORD_BITS      = lsc_pkg::COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = lsc_pkg::PARAM_FRAC_BITS_DEF,
  parameter int unsigned ENTRY_W         = 12 * COORD_BITS + 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  logic [ENTRY_W-1:0] q_data_i,
  output logic               q_pop_o,
  lsc_res_if.source          res
);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned F  = PARAM_FRAC_BITS;
  localparam int unsigned EW = 2 * C + 4;
  localparam int unsigned NS = F + 2;
  localparam int unsigned PT = 4 * C + 2;
  localparam int unsigned PW = F + C + 3;
  localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (F - 1);

  // division pipeline, one quotient bit per stage
  logic [C-1:0]    rem_q [NS][4];
  logic [C-1:0]    np_q  [NS][4];
  logic [F+1:0]    quo_q [NS][4];
  logic [3:0]      flg_q [NS][4];
  logic [PT-1:0]   pt_q  [NS];
  logic [NS-1:0]   dv_q;

  logic [C-1:0]    rem_d [NS][4];
  logic [C-1:0]    np_d  [NS][4];
  logic [F+1:0]    quo_d [NS][4];
  logic [3:0]      flg_d [NS][4];
  logic [PT-1:0]   pt_d  [NS];

  // narrowing stage
  logic                  nv_q, ok_q, ok_d;
  logic [F:0]            t0_q, t1_q, t0_d, t1_d;
  logic [PT-1:0]         npt_q;

  // multiply stage
  logic                  mv_q, mok_q;
  logic signed [PW-1:0]  prod_q [4];
  logic [C-1:0]          bx_q, by_q;
  logic signed [C:0]     m_dx, m_dy;
  logic signed [F+1:0]   m_t0, m_t1;

  logic                  out_valid_q, adv;
  logic                  vis_q;
  logic [C-1:0]          osx_q, osy_q, oex_q, oey_q;
  logic [C-1:0]          osx_d, osy_d, oex_d, oey_d;

  assign adv     = !out_valid_q || res.ready;
  assign q_pop_o = adv && !q_empty_i;

  always_comb begin
    logic [EW-1:0] ed;
    logic [C-1:0]  nq, np;
    logic [C:0]    rem2;
    logic          ge;
    for (int e = 0; e < 4; e++) begin
      ed = q_data_i[e*EW +: EW];
      nq = ed[C-1:0];
      np = ed[2*C-1:C];
      ge = nq >= np;
      rem_d[0][e] = ge ? nq - np : nq;
      np_d[0][e]  = np;
      quo_d[0][e] = {{(F+1){1'b0}}, ge};
      flg_d[0][e] = ed[EW-1:2*C];
    end
    pt_d[0] = q_data_i[4*EW +: PT];
    for (int k = 1; k < NS; k++) begin
      for (int e = 0; e < 4; e++) begin
        rem2 = {rem_q[k-1][e], 1'b0};
        ge   = rem2 >= {1'b0, np_q[k-1][e]};
        rem2 = ge ? rem2 - {1'b0, np_q[k-1][e]} : rem2;
        rem_d[k][e] = rem2[C-1:0];
        np_d[k][e]  = np_q[k-1][e];
        quo_d[k][e] = {quo_q[k-1][e][F:0], ge};
        flg_d[k][e] = flg_q[k-1][e];
      end
      pt_d[k] = pt_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        for (int e = 0; e < 4; e++) begin
          rem_q[k][e] <= rem_d[k][e];
          np_q[k][e]  <= np_d[k][e];
          quo_q[k][e] <= quo_d[k][e];
          flg_q[k][e] <= flg_d[k][e];
        end
        pt_q[k] <= pt_d[k];
      end
    end
  end

  // flags: {parallel, q negative, p negative, saturated}
  always_comb begin
    logic [F+2:0]        sum;
    logic [F+1:0]        mag;
    logic signed [F+2:0] r [4];
    logic signed [F+2:0] t0s, t1s;
    logic [3:0]          fl;
    for (int e = 0; e < 4; e++) begin
      fl   = flg_q[NS-1][e];
      sum  = {1'b0, quo_q[NS-1][e]} + 1'b1;
      mag  = fl[0] ? '1 : sum[F+2:1];
      r[e] = (fl[2] ^ fl[1]) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    ok_d = 1'b1;
    t0_d = '0;
    t1_d = {1'b1, {F{1'b0}}};
    for (int e = 0; e < 4; e++) begin
      fl  = flg_q[NS-1][e];
      t0s = $signed({2'b00, t0_d});
      t1s = $signed({2'b00, t1_d});
      if (ok_d) begin
        if (fl[3]) begin
          if (fl[2]) ok_d = 1'b0;
        end else if (fl[1]) begin
          if (r[e] > t1s) ok_d = 1'b0;
          else if (r[e] > t0s) t0_d = r[e][F:0];
        end else begin
          if (r[e] < t0s) ok_d = 1'b0;
          else if (r[e] < t1s) t1_d = r[e][F:0];
        end
      end
    end
  end

  assign m_dx = npt_q[2*C+1:C+1];
  assign m_dy = npt_q[C:0];
  assign m_t0 = {1'b0, t0_q};
  assign m_t1 = {1'b0, t1_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q  <= ok_d;
      t0_q  <= t0_d;
      t1_q  <= t1_d;
      npt_q <= pt_q[NS-1];
      prod_q[0] <= PW'(m_t0 * m_dx);
      prod_q[1] <= PW'(m_t0 * m_dy);
      prod_q[2] <= PW'(m_t1 * m_dx);
      prod_q[3] <= PW'(m_t1 * m_dy);
      bx_q  <= npt_q[4*C+1:3*C+2];
      by_q  <= npt_q[3*C+1:2*C+2];
      mok_q <= ok_q;
    end
  end

  always_comb begin
    logic signed [PW-1:0] v;
    logic [C-1:0]         fl [4];
    for (int e = 0; e < 4; e++) begin
      v     = (prod_q[e] + HALF) >>> F;
      fl[e] = v[C-1:0];
    end
    res.visible         = vis_q;
    res.clipped_start_x = osx_q;
    res.clipped_start_y = osy_q;
    res.clipped_end_x   = oex_q;
    res.clipped_end_y   = oey_q;
    res.valid           = out_valid_q;
    osx_d = mok_q ? bx_q + fl[0] : '0;
    osy_d = mok_q ? by_q + fl[1] : '0;
    oex_d = mok_q ? bx_q + fl[2] : '0;
    oey_d = mok_q ? by_q + fl[3] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= mok_q;
      osx_q <= osx_d;
      osy_q <= osy_d;
      oex_q <= oex_d;
      oey_q <= oey_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q        <= '0;
      nv_q        <= 1'b0;
      mv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      dv_q        <= {dv_q[NS-2:0], !q_empty_i};
      nv_q        <= dv_q[NS-1];
      mv_q        <= nv_q;
      out_valid_q <= mv_q;
    end
  end

endmodule
